// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SII_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Clocked check that also holds through reset.
`define SII_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/sii_pkg.sv =====
// ----------------------------------------------------------------------------
// sii_pkg
// Shared constants and types of the segment intersection unit.
// ----------------------------------------------------------------------------
package sii_pkg;

	// Coordinate width used inside the datapath is clamped to this range.
	localparam int CW_MIN = 2;
	localparam int CW_MAX = 28;

	localparam logic CMD_SEG = 1'b0;
	localparam logic CMD_BOX = 1'b1;

	// Sideband that travels with an item through the quotient pipeline.
	typedef struct packed {
		logic vld;
		logic hit;
		logic pt_en;
	} ctl_t;

endpackage

// ===== rtl/core/sii_cross_lane.sv =====
// ----------------------------------------------------------------------------
// sii_cross_lane
// One segment test: cross products, sign normalization, range compares.
// ----------------------------------------------------------------------------
module sii_cross_lane #(
	parameter int N = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [N+1:0]  r_x,
	input  logic signed [N+1:0]  r_y,
	input  logic signed [N+1:0]  s_x,
	input  logic signed [N+1:0]  s_y,
	input  logic signed [N+1:0]  w_x,
	input  logic signed [N+1:0]  w_y,
	output logic                 hit_s5,
	output logic [2*N:0]         tn_s5,
	output logic [2*N:0]         det_s5
);

	localparam int P = 2 * N + 4;

	logic signed [P-1:0] rs_a_s2, rs_b_s2, ws_a_s2, ws_b_s2, wr_a_s2, wr_b_s2;
	logic signed [P-1:0] det_s3, tn_s3, un_s3;
	logic signed [P-1:0] det_s4, tn_s4, un_s4;
	logic                zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rs_a_s2 <= r_x * s_y;
			rs_b_s2 <= r_y * s_x;
			ws_a_s2 <= w_x * s_y;
			ws_b_s2 <= w_y * s_x;
			wr_a_s2 <= w_x * r_y;
			wr_b_s2 <= w_y * r_x;

			det_s3 <= rs_a_s2 - rs_b_s2;
			tn_s3  <= ws_a_s2 - ws_b_s2;
			un_s3  <= wr_a_s2 - wr_b_s2;

			// make the determinant non-negative
			zero_s4 <= (det_s3 == '0);
			det_s4  <= det_s3[P-1] ? -det_s3 : det_s3;
			tn_s4   <= det_s3[P-1] ? -tn_s3 : tn_s3;
			un_s4   <= det_s3[P-1] ? -un_s3 : un_s3;

			hit_s5 <= !zero_s4 && !tn_s4[P-1] && (tn_s4 <= det_s4)
				&& !un_s4[P-1] && (un_s4 <= det_s4);
			tn_s5  <= tn_s4[2*N:0];
			det_s5 <= det_s4[2*N:0];
		end
	end

endmodule

// ===== rtl/core/sii_quot_pipe.sv =====
// ----------------------------------------------------------------------------
// sii_quot_pipe
// Pipelined scaled quotient floor(|r| * tn / det), one bit of |r| per stage,
// both axes side by side.
// ----------------------------------------------------------------------------
module sii_quot_pipe #(
	parameter int N = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  sii_pkg::ctl_t        ctl_in,
	input  logic [2*N:0]         tn,
	input  logic [2*N:0]         det,
	input  logic [N-1:0]         mag_x,
	input  logic [N-1:0]         mag_y,
	input  logic                 neg_x,
	input  logic                 neg_y,
	input  logic [N-1:0]         a_x,
	input  logic [N-1:0]         a_y,
	output sii_pkg::ctl_t        ctl_out,
	output logic [N-1:0]         q_x,
	output logic [N-1:0]         q_y,
	output logic                 neg_x_out,
	output logic                 neg_y_out,
	output logic [N-1:0]         a_x_out,
	output logic [N-1:0]         a_y_out
);

	localparam int RW = 2 * N + 1;

	sii_pkg::ctl_t  ctl_s   [N];
	logic [RW-1:0]  rem_x_s [N];
	logic [RW-1:0]  rem_y_s [N];
	logic [N-1:0]   quo_x_s [N];
	logic [N-1:0]   quo_y_s [N];
	logic [RW-1:0]  tn_s    [N];
	logic [RW-1:0]  det_s   [N];
	logic [N-1:0]   mag_x_s [N];
	logic [N-1:0]   mag_y_s [N];
	logic           neg_x_s [N];
	logic           neg_y_s [N];
	logic [N-1:0]   a_x_s   [N];
	logic [N-1:0]   a_y_s   [N];

	// rem < det and tn <= det, so 2*rem + tn < 3*det: at most two subtracts.
	function automatic logic [RW+1:0] div_step(input logic [RW-1:0] rm,
		input logic [RW-1:0] tv, input logic [RW-1:0] dv, input logic b);
		logic [RW+1:0] x;
		logic [RW+1:0] d1;
		logic [RW+1:0] d2;
		x  = {1'b0, rm, 1'b0} + (b ? {2'b00, tv} : '0);
		d1 = {2'b00, dv};
		d2 = {1'b0, dv, 1'b0};
		if (x >= d2)
			div_step = {2'd2, RW'(x - d2)};
		else if (x >= d1)
			div_step = {2'd1, RW'(x - d1)};
		else
			div_step = {2'd0, x[RW-1:0]};
	endfunction

	for (genvar j = 0; j < N; j++) begin : g_stage
		sii_pkg::ctl_t ctl_c;
		logic [RW-1:0] rem_x_c, rem_y_c, tn_c, det_c;
		logic [N-1:0]  quo_x_c, quo_y_c, mag_x_c, mag_y_c, a_x_c, a_y_c;
		logic          neg_x_c, neg_y_c;
		logic [RW+1:0] st_x, st_y;

		if (j == 0) begin : g_first
			assign ctl_c   = ctl_in;
			assign rem_x_c = '0;
			assign rem_y_c = '0;
			assign quo_x_c = '0;
			assign quo_y_c = '0;
			assign tn_c    = tn;
			assign det_c   = det;
			assign mag_x_c = mag_x;
			assign mag_y_c = mag_y;
			assign neg_x_c = neg_x;
			assign neg_y_c = neg_y;
			assign a_x_c   = a_x;
			assign a_y_c   = a_y;
		end else begin : g_next
			assign ctl_c   = ctl_s[j-1];
			assign rem_x_c = rem_x_s[j-1];
			assign rem_y_c = rem_y_s[j-1];
			assign quo_x_c = quo_x_s[j-1];
			assign quo_y_c = quo_y_s[j-1];
			assign tn_c    = tn_s[j-1];
			assign det_c   = det_s[j-1];
			assign mag_x_c = mag_x_s[j-1];
			assign mag_y_c = mag_y_s[j-1];
			assign neg_x_c = neg_x_s[j-1];
			assign neg_y_c = neg_y_s[j-1];
			assign a_x_c   = a_x_s[j-1];
			assign a_y_c   = a_y_s[j-1];
		end

		assign st_x = div_step(rem_x_c, tn_c, det_c, mag_x_c[N-1-j]);
		assign st_y = div_step(rem_y_c, tn_c, det_c, mag_y_c[N-1-j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else if (en) begin
				ctl_s[j] <= ctl_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[j] <= st_x[RW-1:0];
				rem_y_s[j] <= st_y[RW-1:0];
				quo_x_s[j] <= N'({quo_x_c, 1'b0} + (N+1)'(st_x[RW+1:RW]));
				quo_y_s[j] <= N'({quo_y_c, 1'b0} + (N+1)'(st_y[RW+1:RW]));
				tn_s[j]    <= tn_c;
				det_s[j]   <= det_c;
				mag_x_s[j] <= mag_x_c;
				mag_y_s[j] <= mag_y_c;
				neg_x_s[j] <= neg_x_c;
				neg_y_s[j] <= neg_y_c;
				a_x_s[j]   <= a_x_c;
				a_y_s[j]   <= a_y_c;
			end
		end
	end

	assign ctl_out   = ctl_s[N-1];
	assign q_x       = quo_x_s[N-1];
	assign q_y       = quo_y_s[N-1];
	assign neg_x_out = neg_x_s[N-1];
	assign neg_y_out = neg_y_s[N-1];
	assign a_x_out   = a_x_s[N-1];
	assign a_y_out   = a_y_s[N-1];

endmodule

// ===== rtl/core/segment_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Segment/segment and segment/box intersection on signed integer coordinates.
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// in      | in_valid / in_stall    | command, seg_start_*, seg_end_*, shape_a_*, shape_b_*
// out     | out_valid / out_stall  | hit, point_x, point_y
//
// One transfer per cycle in while in_stall is low, one per cycle out while
// out_stall is low. N = COORD_BITS clamped to 2..28 (16 at the default) is
// the width of |r|, of which the quotient pipeline retires one bit per stage.
// Reset clears only the valid bits and the sideband of the quotient pipeline;
// the block is ready right after reset.
// A stalled result is caught in a one-entry skid register; in_stall is that
// register's full flag, so the pipeline never drops or repeats a transfer.
// ----------------------------------------------------------------------------
module segment_intersection_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic signed [COORD_BITS-1:0]  seg_start_x,
	input  logic signed [COORD_BITS-1:0]  seg_start_y,
	input  logic signed [COORD_BITS-1:0]  seg_end_x,
	input  logic signed [COORD_BITS-1:0]  seg_end_y,
	input  logic signed [COORD_BITS-1:0]  shape_a_x,
	input  logic signed [COORD_BITS-1:0]  shape_a_y,
	input  logic signed [COORD_BITS-1:0]  shape_b_x,
	input  logic signed [COORD_BITS-1:0]  shape_b_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic signed [COORD_BITS-1:0]  point_x,
	output logic signed [COORD_BITS-1:0]  point_y
);

	localparam int N  = (COORD_BITS > sii_pkg::CW_MAX) ? sii_pkg::CW_MAX :
		((COORD_BITS < sii_pkg::CW_MIN) ? sii_pkg::CW_MIN : COORD_BITS);
	localparam int V  = N + 2;
	localparam int RW = 2 * N + 1;
	localparam int SW = 3 + 4 * N;

	logic en;

	// operand preparation
	logic signed [V-1:0] ax, ay, bx, by, cax, cay, cbx, cby;
	logic signed [V-1:0] x0, x1, y0, y1, rx, ry;
	logic signed [V-1:0] c_x [4];
	logic signed [V-1:0] c_y [4];
	logic signed [V-1:0] d_x [4];
	logic signed [V-1:0] d_y [4];
	logic [V-1:0]        mrx, mry;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [V-1:0] r_x_s1, r_y_s1;
	logic signed [V-1:0] s_x_s1 [4];
	logic signed [V-1:0] s_y_s1 [4];
	logic signed [V-1:0] w_x_s1 [4];
	logic signed [V-1:0] w_y_s1 [4];
	logic [SW-1:0]       side_s1, side_s2, side_s3, side_s4, side_s5;

	logic [3:0]          h_s5;
	logic [RW-1:0]       tn0_s5, det0_s5;

	logic                cmd5, negx5, negy5;
	logic [N-1:0]        ax5, ay5, mx5, my5;
	sii_pkg::ctl_t       ctl5, ctl_q;
	logic [N-1:0]        qx, qy, aqx, aqy;
	logic                nqx, nqy;

	logic                vld_so, hit_so;
	logic [N-1:0]        px_so, py_so;
	logic                skid_v_q, skid_hit_q;
	logic [N-1:0]        skid_px_q, skid_py_q;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	always_comb begin
		ax  = $signed({{2{seg_start_x[N-1]}}, seg_start_x[N-1:0]});
		ay  = $signed({{2{seg_start_y[N-1]}}, seg_start_y[N-1:0]});
		bx  = $signed({{2{seg_end_x[N-1]}}, seg_end_x[N-1:0]});
		by  = $signed({{2{seg_end_y[N-1]}}, seg_end_y[N-1:0]});
		cax = $signed({{2{shape_a_x[N-1]}}, shape_a_x[N-1:0]});
		cay = $signed({{2{shape_a_y[N-1]}}, shape_a_y[N-1:0]});
		cbx = $signed({{2{shape_b_x[N-1]}}, shape_b_x[N-1:0]});
		cby = $signed({{2{shape_b_y[N-1]}}, shape_b_y[N-1:0]});

		x0 = cax - cbx;
		x1 = cax + cbx;
		y0 = cay - cby;
		y1 = cay + cby;
		rx = bx - ax;
		ry = by - ay;
		mrx = rx[V-1] ? -rx : rx;
		mry = ry[V-1] ? -ry : ry;

		// lane 0 is the second segment, or the bottom side of the box
		c_x[0] = (command == sii_pkg::CMD_BOX) ? x0 : cax;
		c_y[0] = (command == sii_pkg::CMD_BOX) ? y0 : cay;
		d_x[0] = (command == sii_pkg::CMD_BOX) ? x1 : cbx;
		d_y[0] = (command == sii_pkg::CMD_BOX) ? y0 : cby;
		c_x[1] = x1; c_y[1] = y0; d_x[1] = x1; d_y[1] = y1;
		c_x[2] = x0; c_y[2] = y1; d_x[2] = x1; d_y[2] = y1;
		c_x[3] = x0; c_y[3] = y0; d_x[3] = x0; d_y[3] = y1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_x_s1 <= rx;
			r_y_s1 <= ry;
			for (int l = 0; l < 4; l++) begin
				s_x_s1[l] <= d_x[l] - c_x[l];
				s_y_s1[l] <= d_y[l] - c_y[l];
				w_x_s1[l] <= c_x[l] - ax;
				w_y_s1[l] <= c_y[l] - ay;
			end
			side_s1 <= {command, rx[V-1], ry[V-1], ax[N-1:0], ay[N-1:0],
				mrx[N-1:0], mry[N-1:0]};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		if (l == 0) begin : g_main
			sii_cross_lane #(.N(N)) u_lane (
				.clk    (clk),
				.en     (en),
				.r_x    (r_x_s1),
				.r_y    (r_y_s1),
				.s_x    (s_x_s1[l]),
				.s_y    (s_y_s1[l]),
				.w_x    (w_x_s1[l]),
				.w_y    (w_y_s1[l]),
				.hit_s5 (h_s5[l]),
				.tn_s5  (tn0_s5),
				.det_s5 (det0_s5)
			);
		end else begin : g_side
			sii_cross_lane #(.N(N)) u_lane (
				.clk    (clk),
				.en     (en),
				.r_x    (r_x_s1),
				.r_y    (r_y_s1),
				.s_x    (s_x_s1[l]),
				.s_y    (s_y_s1[l]),
				.w_x    (w_x_s1[l]),
				.w_y    (w_y_s1[l]),
				.hit_s5 (h_s5[l]),
				.tn_s5  (),
				.det_s5 ()
			);
		end
	end

	assign {cmd5, negx5, negy5, ax5, ay5, mx5, my5} = side_s5;

	always_comb begin
		ctl5.vld   = vld_s5;
		ctl5.pt_en = (cmd5 == sii_pkg::CMD_SEG) && h_s5[0];
		ctl5.hit   = (cmd5 == sii_pkg::CMD_SEG) ? h_s5[0] : (|h_s5);
	end

	sii_quot_pipe #(.N(N)) u_quot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ctl5),
		.tn        (tn0_s5),
		.det       (det0_s5),
		.mag_x     (mx5),
		.mag_y     (my5),
		.neg_x     (negx5),
		.neg_y     (negy5),
		.a_x       (ax5),
		.a_y       (ay5),
		.ctl_out   (ctl_q),
		.q_x       (qx),
		.q_y       (qy),
		.neg_x_out (nqx),
		.neg_y_out (nqy),
		.a_x_out   (aqx),
		.a_y_out   (aqy)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (en) begin
			vld_so <= ctl_q.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_so <= ctl_q.hit;
			px_so  <= ctl_q.pt_en ? (nqx ? aqx - qx : aqx + qx) : '0;
			py_so  <= ctl_q.pt_en ? (nqy ? aqy - qy : aqy + qy) : '0;
		end
	end

	// skid: holds the output item when the pipeline moves under a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= vld_so && out_stall;
		end else if (!out_stall) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skid_hit_q <= hit_so;
			skid_px_q  <= px_so;
			skid_py_q  <= py_so;
		end
	end

	assign out_valid = skid_v_q || vld_so;
	assign hit       = skid_v_q ? skid_hit_q : hit_so;
	assign point_x   = COORD_BITS'(skid_v_q ? skid_px_q : px_so);
	assign point_y   = COORD_BITS'(skid_v_q ? skid_py_q : py_so);

endmodule

// ===== rtl/core/sii_checker.sv =====
// ----------------------------------------------------------------------------
// sii_checker
// Port-level checks of the segment intersection unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sii_checker #(
	parameter int COORD_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic                   hit,
	input logic [COORD_BITS-1:0]  point_x,
	input logic [COORD_BITS-1:0]  point_y
);

	`SII_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output dropped while stalled")
	`SII_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(hit) && $stable(point_x) && $stable(point_y), "stalled result changed")
	`SII_ASSERT(a_miss_zero, out_valid && !hit |-> point_x == '0 && point_y == '0, "point on a miss")
	`SII_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "input stall without output stall")
	`SII_ASSERT_ALWAYS(a_stall_valid, in_stall |-> out_valid, "input stalled with no pending result")

endmodule

bind segment_intersection_unit sii_checker #(.COORD_BITS(COORD_BITS)) u_sii_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.point_x   (point_x),
	.point_y   (point_y)
);
